/* hdl/segment_closest_point_query_core_assert.svh */
// assertion macros shared by the segment query block
// each macro checks on the rising edge of clk and is held off while rst is high
`ifndef SEGMENT_CLOSEST_POINT_QUERY_CORE_ASSERT_SVH
`define SEGMENT_CLOSEST_POINT_QUERY_CORE_ASSERT_SVH

// same-cycle implication
`define SCPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/seg_cpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seg_cpq_pkg
// Shared types and constants for the nearest-segment point query block.
// ----------------------------------------------------------------------------
package seg_cpq_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int ID_WIDTH        = 32;
  localparam int REQ_WIDTH       = 2;
  localparam int Q_DEPTH         = 2;

  // request codes on the input side
  localparam logic [REQ_WIDTH-1:0] REQ_BEGIN   = 2'd0;
  localparam logic [REQ_WIDTH-1:0] REQ_SEGMENT = 2'd1;
  localparam logic [REQ_WIDTH-1:0] REQ_FINISH  = 2'd2;

  // classified command kinds in the queue
  typedef enum logic [1:0] {
    CMD_BEGIN,
    CMD_SEGMENT,
    CMD_FINISH
  } cmd_kind_t;

  // queue head control seen by the back end
  typedef struct packed {
    logic      valid;
    cmd_kind_t kind;
  } cmd_ctl_t;

  // back end sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_P0,
    S_P1,
    S_P2,
    S_P3,
    S_P4,
    S_CLS,
    S_DIV,
    S_SC0,
    S_SC1,
    S_SC2,
    S_DX,
    S_Q0,
    S_Q1,
    S_Q2,
    S_SQ,
    S_UPD
  } bst_t;

endpackage

/* hdl/seg_cpq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seg_cpq_front
// Accepts request items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module seg_cpq_front #(
  parameter int CW = seg_cpq_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [seg_cpq_pkg::REQ_WIDTH-1:0]   req_type,
  input  logic signed [CW-1:0]                query_x,
  input  logic signed [CW-1:0]                query_y,
  input  logic [CW-1:0]                       query_radius,
  input  logic signed [CW-1:0]                seg_x0,
  input  logic signed [CW-1:0]                seg_y0,
  input  logic signed [CW-1:0]                seg_x1,
  input  logic signed [CW-1:0]                seg_y1,
  input  logic [seg_cpq_pkg::ID_WIDTH-1:0]    prim_id,
  input  logic [seg_cpq_pkg::ID_WIDTH-1:0]    geom_id,
  input  logic                                flip,
  input  logic [seg_cpq_pkg::ID_WIDTH-1:0]    prim_offset,
  output seg_cpq_pkg::cmd_ctl_t               ctl,
  output logic [4*CW+3*seg_cpq_pkg::ID_WIDTH:0] data,
  input  logic                                pop
);
  import seg_cpq_pkg::*;

  localparam int DW = 4 * CW + 3 * ID_WIDTH + 1;
  localparam int PW = $clog2(Q_DEPTH);
  localparam int CNW = $clog2(Q_DEPTH + 1);

  logic [DW-1:0] qdata [Q_DEPTH];
  cmd_kind_t     qkind [Q_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CNW-1:0] cnt;

  logic          keep;
  cmd_kind_t     kind;
  logic [CW-1:0] fa, fb, fc, fd;
  logic          wr, rd;

  // classify the request and place its fields in shared slots
  always_comb begin
    keep = 1'b1;
    kind = CMD_FINISH;
    fa = '0;
    fb = '0;
    fc = '0;
    fd = '0;
    case (req_type)
      REQ_BEGIN: begin
        kind = CMD_BEGIN;
        fa = query_x;
        fb = query_y;
        fc = query_radius;
      end
      REQ_SEGMENT: begin
        kind = CMD_SEGMENT;
        fa = seg_x0;
        fb = seg_y0;
        fc = seg_x1;
        fd = seg_y1;
      end
      REQ_FINISH: begin
        kind = CMD_FINISH;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full = (cnt == CNW'(Q_DEPTH));
  assign wr   = push && !full && keep;
  assign rd   = pop && (cnt != '0);

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      qdata[wptr] <= {flip, prim_offset, geom_id, prim_id, fd, fc, fb, fa};
      qkind[wptr] <= kind;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr) wptr <= (wptr == PW'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (rd) rptr <= (rptr == PW'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (wr && !rd) cnt <= cnt + 1'b1;
      else if (rd && !wr) cnt <= cnt - 1'b1;
    end
  end

  // head of queue
  assign ctl.valid = (cnt != '0);
  assign ctl.kind  = qkind[rptr];
  assign data      = qdata[rptr];

endmodule

/* hdl/seg_cpq_back.sv */
`timescale 1ns / 1ps
`include "segment_closest_point_query_core_assert.svh"
// ----------------------------------------------------------------------------
// seg_cpq_back
// Executes queued commands: projection, divide, clamp, square root, best hit.
// ----------------------------------------------------------------------------
module seg_cpq_back #(
  parameter int CW = seg_cpq_pkg::COORD_WIDTH_DEF,
  parameter int FB = seg_cpq_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  seg_cpq_pkg::cmd_ctl_t               ctl,
  input  logic [4*CW+3*seg_cpq_pkg::ID_WIDTH:0] data,
  output logic                                q_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic                                status,
  output logic                                found,
  output logic [seg_cpq_pkg::ID_WIDTH-1:0]    hit_prim,
  output logic [seg_cpq_pkg::ID_WIDTH-1:0]    hit_geom,
  output logic [seg_cpq_pkg::ID_WIDTH-1:0]    hit_scene_prim,
  output logic signed [CW:0]                  normal_x,
  output logic signed [CW:0]                  normal_y,
  output logic [FB:0]                         param_s,
  output logic [CW-1:0]                       distance
);
  import seg_cpq_pkg::*;

  localparam int MW   = (CW + 2 > FB + 2) ? CW + 2 : FB + 2;
  localparam int PW   = 2 * MW;
  localparam int AW   = PW + 1;
  localparam int RW   = MW;
  localparam int SW   = FB + 1;
  localparam int CNTW = $clog2(RW);
  localparam int IW   = ID_WIDTH;

  // queue head fields
  logic [CW-1:0] fa, fb, fc, fd;
  logic [IW-1:0] in_prim, in_geom, in_off;
  logic          in_flip;
  logic signed [MW-1:0] in_x0, in_y0, in_x1, in_y1;

  assign fa      = data[CW-1:0];
  assign fb      = data[2*CW-1:CW];
  assign fc      = data[3*CW-1:2*CW];
  assign fd      = data[4*CW-1:3*CW];
  assign in_prim = data[4*CW+IW-1:4*CW];
  assign in_geom = data[4*CW+2*IW-1:4*CW+IW];
  assign in_off  = data[4*CW+3*IW-1:4*CW+2*IW];
  assign in_flip = data[4*CW+3*IW];
  assign in_x0   = MW'(signed'(fa));
  assign in_y0   = MW'(signed'(fb));
  assign in_x1   = MW'(signed'(fc));
  assign in_y1   = MW'(signed'(fd));

  bst_t state, state_next;

  // query state
  logic signed [CW-1:0] px, py;
  logic [CW-1:0]        radius;
  logic                 query_ok;
  logic                 have_hit;
  logic [IW-1:0]        best_prim, best_geom, best_scene_prim;
  logic signed [CW:0]   best_normal_x, best_normal_y;
  logic [SW-1:0]        best_param;
  logic [CW-1:0]        best_distance;

  // segment working registers
  logic signed [MW-1:0] x0, y0, x1, y1, ex, ey, vx, vy;
  logic signed [MW-1:0] cx, cy, dx, dy;
  logic                 sflip;
  logic [IW-1:0]        sprim, sgeom, soff;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc, dval, len;
  logic [AW:0]          rem;
  logic [SW-1:0]        sval;
  logic [CNTW-1:0]      cnt;
  logic [2*RW-1:0]      rad;
  logic [RW-1:0]        root;
  logic [RW+1:0]        srem;
  logic                 out_valid;

  // shared multiplier operand select
  logic signed [MW-1:0] ma, mb, s_ext;
  logic signed [AW-1:0] accsum;

  assign s_ext  = signed'({{(MW - SW){1'b0}}, sval});
  assign accsum = acc + prod;

  always_comb begin
    case (state)
      S_P0:    begin ma = vx; mb = ex; end
      S_P1:    begin ma = vy; mb = ey; end
      S_P2:    begin ma = ex; mb = ex; end
      S_P3:    begin ma = ey; mb = ey; end
      S_SC0:   begin ma = ex; mb = s_ext; end
      S_SC1:   begin ma = ey; mb = s_ext; end
      S_Q0:    begin ma = dx; mb = dx; end
      S_Q1:    begin ma = dy; mb = dy; end
      default: begin ma = ex; mb = ey; end
    endcase
  end

  // divide step
  logic [AW:0] len_ext, rem2;
  logic        div_ge;
  assign len_ext = {1'b0, len};
  assign rem2    = {rem[AW-1:0], 1'b0};
  assign div_ge  = (rem2 >= len_ext);

  // square root step
  logic [RW+2:0] rem_t, trial, sq_diff;
  logic          sq_ge;
  assign rem_t   = {srem[RW:0], rad[2*RW-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign sq_ge   = (rem_t >= trial);
  assign sq_diff = rem_t - trial;

  // clamp decisions
  logic clamp_lo, clamp_hi, closer;
  assign clamp_lo = (dval <= 0);
  assign clamp_hi = (dval >= len);
  assign closer   = (root < RW'(radius));

  // normal of the recorded segment
  logic signed [CW:0] nx_raw, ny_raw;
  assign nx_raw = ey[CW:0];
  assign ny_raw = -ex[CW:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and queue pop
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      S_IDLE: begin
        if (ctl.valid) begin
          case (ctl.kind)
            CMD_BEGIN: q_pop = 1'b1;
            CMD_SEGMENT: begin
              q_pop = 1'b1;
              if (query_ok) state_next = S_P0;
            end
            CMD_FINISH: q_pop = !out_valid;
            default: q_pop = 1'b1;
          endcase
        end
      end
      S_P0:  state_next = S_P1;
      S_P1:  state_next = S_P2;
      S_P2:  state_next = S_P3;
      S_P3:  state_next = S_P4;
      S_P4:  state_next = S_CLS;
      S_CLS: state_next = (clamp_lo || clamp_hi) ? S_DX : S_DIV;
      S_DIV: if (cnt == CNTW'(FB - 1)) state_next = S_SC0;
      S_SC0: state_next = S_SC1;
      S_SC1: state_next = S_SC2;
      S_SC2: state_next = S_DX;
      S_DX:  state_next = S_Q0;
      S_Q0:  state_next = S_Q1;
      S_Q1:  state_next = S_Q2;
      S_Q2:  state_next = S_SQ;
      S_SQ:  if (cnt == CNTW'(RW - 1)) state_next = S_UPD;
      S_UPD: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // segment datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (ctl.valid && ctl.kind == CMD_SEGMENT) begin
          x0 <= in_x0;
          y0 <= in_y0;
          x1 <= in_x1;
          y1 <= in_y1;
          ex <= in_x1 - in_x0;
          ey <= in_y1 - in_y0;
          vx <= MW'(px) - in_x0;
          vy <= MW'(py) - in_y0;
          sflip <= in_flip;
          sprim <= in_prim;
          sgeom <= in_geom;
          soff  <= in_off;
        end
      end
      S_P1: acc <= AW'(prod);
      S_P2: dval <= accsum;
      S_P3: acc <= AW'(prod);
      S_P4: len <= accsum;
      S_CLS: begin
        cnt <= '0;
        rem <= {1'b0, dval};
        if (clamp_lo) begin
          sval <= '0;
          cx <= x0;
          cy <= y0;
        end else if (clamp_hi) begin
          sval <= SW'(1) << FB;
          cx <= x1;
          cy <= y1;
        end else begin
          sval <= '0;
        end
      end
      S_DIV: begin
        rem  <= div_ge ? rem2 - len_ext : rem2;
        sval <= {sval[SW-2:0], div_ge};
        cnt  <= cnt + 1'b1;
      end
      S_SC1: cx <= x0 + MW'(prod >>> FB);
      S_SC2: cy <= y0 + MW'(prod >>> FB);
      S_DX: begin
        dx <= cx - MW'(px);
        dy <= cy - MW'(py);
      end
      S_Q1: acc <= AW'(prod);
      S_Q2: begin
        rad  <= accsum[2*RW-1:0];
        root <= '0;
        srem <= '0;
        cnt  <= '0;
      end
      S_SQ: begin
        srem <= sq_ge ? sq_diff[RW+1:0] : rem_t[RW+1:0];
        root <= {root[RW-2:0], sq_ge};
        rad  <= {rad[2*RW-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // query state and best hit
  always_ff @(posedge clk) begin
    if (rst) begin
      query_ok        <= 1'b0;
      have_hit        <= 1'b0;
      best_prim       <= '0;
      best_geom       <= '0;
      best_scene_prim <= '0;
      best_normal_x   <= '0;
      best_normal_y   <= '0;
      best_param      <= '0;
      best_distance   <= '0;
      radius          <= '0;
      px              <= '0;
      py              <= '0;
    end else if (state == S_IDLE && ctl.valid && ctl.kind == CMD_BEGIN) begin
      px              <= signed'(fa);
      py              <= signed'(fb);
      radius          <= fc;
      query_ok        <= (fc != '0);
      have_hit        <= 1'b0;
      best_prim       <= '0;
      best_geom       <= '0;
      best_scene_prim <= '0;
      best_normal_x   <= '0;
      best_normal_y   <= '0;
      best_param      <= '0;
      best_distance   <= '0;
    end else if (state == S_UPD && closer) begin
      // a closer root is below the radius, so it always fits the distance field
      have_hit        <= 1'b1;
      best_prim       <= sprim;
      best_geom       <= sgeom;
      best_scene_prim <= sprim + soff;
      best_normal_x   <= sflip ? -nx_raw : nx_raw;
      best_normal_y   <= sflip ? -ny_raw : ny_raw;
      best_param      <= sval;
      best_distance   <= root[CW-1:0];
      radius          <= root[CW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && ctl.kind == CMD_FINISH) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && ctl.kind == CMD_FINISH) begin
      status         <= !query_ok;
      found          <= have_hit;
      hit_prim       <= best_prim;
      hit_geom       <= best_geom;
      hit_scene_prim <= best_scene_prim;
      normal_x       <= best_normal_x;
      normal_y       <= best_normal_y;
      param_s        <= best_param;
      distance       <= best_distance;
    end
  end

  assign empty = !out_valid;

  `SCPQ_ASSERT_IMP(a_pop_idle, q_pop, state == S_IDLE, "queue popped while busy")
  `SCPQ_ASSERT_IMP(a_div_rem, state == S_DIV, rem < len_ext, "divide remainder out of range")
  `SCPQ_ASSERT_IMP(a_fin_free, q_pop && ctl.kind == CMD_FINISH, !out_valid,
                   "finish item overwrote a waiting result")
  `SCPQ_ASSERT_NXT(a_seg_start, q_pop && ctl.kind == CMD_SEGMENT && query_ok,
                   state == S_P0, "valid segment item did not start")

endmodule

/* hdl/segment_closest_point_query_core.sv */
`timescale 1ns / 1ps
// Begin items pass through the queue to the back end, which loads the query state; a finish
// item loads the result register once the previous result has been popped. A segment item
// of a valid query runs projection, the bit-serial divide, scale and the two-bit-per-cycle
// square root, with one multiplier shared by projection, scale and squared distance; a clamped
// segment skips divide and scale. No item is popped while a segment is in progress.
// Reset (rst, synchronous) empties the queue and result register and clears query state.
// ----------------------------------------------------------------------------
// segment_closest_point_query_core
// Nearest-segment point query: front classifier and queue, back execution unit.
// ----------------------------------------------------------------------------
module segment_closest_point_query_core #(
  parameter int COORD_WIDTH = seg_cpq_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = seg_cpq_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [seg_cpq_pkg::REQ_WIDTH-1:0] req_type,
  input  logic signed [COORD_WIDTH-1:0]     query_x,
  input  logic signed [COORD_WIDTH-1:0]     query_y,
  input  logic [COORD_WIDTH-1:0]            query_radius,
  input  logic signed [COORD_WIDTH-1:0]     seg_x0,
  input  logic signed [COORD_WIDTH-1:0]     seg_y0,
  input  logic signed [COORD_WIDTH-1:0]     seg_x1,
  input  logic signed [COORD_WIDTH-1:0]     seg_y1,
  input  logic [seg_cpq_pkg::ID_WIDTH-1:0]  prim_id,
  input  logic [seg_cpq_pkg::ID_WIDTH-1:0]  geom_id,
  input  logic                              flip,
  input  logic [seg_cpq_pkg::ID_WIDTH-1:0]  prim_offset,
  output logic                              empty,
  input  logic                              pop,
  output logic                              status,
  output logic                              found,
  output logic [seg_cpq_pkg::ID_WIDTH-1:0]  hit_prim,
  output logic [seg_cpq_pkg::ID_WIDTH-1:0]  hit_geom,
  output logic [seg_cpq_pkg::ID_WIDTH-1:0]  hit_scene_prim,
  output logic signed [COORD_WIDTH:0]       normal_x,
  output logic signed [COORD_WIDTH:0]       normal_y,
  output logic [FRAC_BITS:0]                param_s,
  output logic [COORD_WIDTH-1:0]            distance
);
  import seg_cpq_pkg::*;

  localparam int DW = 4 * COORD_WIDTH + 3 * ID_WIDTH + 1;

  cmd_ctl_t      ctl;
  logic [DW-1:0] data;
  logic          q_pop;

  // front: classify and queue items
  seg_cpq_front #(.CW(COORD_WIDTH)) u_front (
    .clk, .rst, .push, .full, .req_type,
    .query_x, .query_y, .query_radius,
    .seg_x0, .seg_y0, .seg_x1, .seg_y1,
    .prim_id, .geom_id, .flip, .prim_offset,
    .ctl, .data, .pop(q_pop)
  );

  // back: execute commands and hold the result
  seg_cpq_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk, .rst, .ctl, .data, .q_pop,
    .empty, .pop,
    .status, .found, .hit_prim, .hit_geom, .hit_scene_prim,
    .normal_x, .normal_y, .param_s, .distance
  );

endmodule

/* dv/tb_segment_closest_point_query_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_closest_point_query_core
// Drives query sequences (begin, candidate segments, finish) through the
// queue-style ports and checks every emitted nearest-hit result against a
// bit-exact fixed-point predictor kept inside this bench.
// ----------------------------------------------------------------------------
module tb_segment_closest_point_query_core;
  import seg_cpq_pkg::*;

  // request code with no meaning, must be ignored
  localparam logic [REQ_WIDTH-1:0] REQ_SPARE = 2'd3;
  localparam int MIN_C = 32'sh8000_0000;
  localparam int MAX_C = 32'sh7fff_ffff;

  typedef struct {
    bit        status;
    bit        found;
    bit [31:0] prim;
    bit [31:0] geom;
    bit [31:0] scene;
    bit [32:0] nx;
    bit [32:0] ny;
    bit [16:0] param;
    bit [31:0] dst;
  } hit_t;

  typedef struct {
    bit [1:0]  req;
    int        qx, qy;
    bit [31:0] rad;
    int        x0, y0, x1, y1;
    bit [31:0] prim, geom, off;
    bit        flip;
    bit        fixed;
    hit_t      want;
  } query_item_t;

  logic clk, rst, push, full, empty, pop;
  logic [REQ_WIDTH-1:0] req_type;
  logic signed [31:0] query_x, query_y, seg_x0, seg_y0, seg_x1, seg_y1;
  logic [31:0] query_radius, prim_id, geom_id, prim_offset;
  logic flip;
  logic status, found;
  logic [31:0] hit_prim, hit_geom, hit_scene_prim, distance;
  logic signed [32:0] normal_x, normal_y;
  logic [16:0] param_s;

  segment_closest_point_query_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .query_x(query_x), .query_y(query_y), .query_radius(query_radius),
    .seg_x0(seg_x0), .seg_y0(seg_y0), .seg_x1(seg_x1), .seg_y1(seg_y1),
    .prim_id(prim_id), .geom_id(geom_id), .flip(flip), .prim_offset(prim_offset),
    .empty(empty), .pop(pop), .status(status), .found(found),
    .hit_prim(hit_prim), .hit_geom(hit_geom), .hit_scene_prim(hit_scene_prim),
    .normal_x(normal_x), .normal_y(normal_y), .param_s(param_s), .distance(distance)
  );

  query_item_t stim_q[$];
  hit_t        hit_expq[$];
  int          mismatches = 0;
  int          cyc = 0;
  bit          stim_done = 0;

  // query state mirrored by the predictor
  longint    pt_x, pt_y;
  bit [31:0] radius;
  bit        query_ok, have_hit;
  hit_t      best;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic bit calm();
    return cyc >= 15000 && cyc < 30000;
  endfunction

  function automatic bit idle_now();
    return !calm() && $urandom_range(99) < 11;
  endfunction

  function automatic longint unsigned isqrt(logic [127:0] v);
    longint unsigned res, cand;
    res = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
    end
    return res;
  endfunction

  function automatic void clear_best();
    have_hit = 0;
    best = '{default: 0};
  endfunction

  // closest point on the segment, distance, and best-hit update
  function automatic void measure_segment(query_item_t it);
    logic signed [127:0] ex, ey, vx, vy, d, len2, s, cx, cy, dx, dy;
    longint unsigned dist_v;
    bit [32:0] nx, ny;
    ex = longint'(it.x1) - longint'(it.x0);
    ey = longint'(it.y1) - longint'(it.y0);
    vx = pt_x - longint'(it.x0);
    vy = pt_y - longint'(it.y0);
    d = vx * ex + vy * ey;
    len2 = ex * ex + ey * ey;
    if (d <= 0) begin
      s = 0; cx = it.x0; cy = it.y0;
    end else if (d >= len2) begin
      s = 65536; cx = it.x1; cy = it.y1;
    end else begin
      s = (d <<< 16) / len2;
      cx = longint'(it.x0) + ((ex * s) >>> 16);
      cy = longint'(it.y0) + ((ey * s) >>> 16);
    end
    dx = cx - pt_x;
    dy = cy - pt_y;
    dist_v = isqrt(dx * dx + dy * dy);
    if (dist_v >= {32'd0, radius}) return;
    nx = 33'(longint'(it.y1) - longint'(it.y0));
    ny = 33'(longint'(it.x0) - longint'(it.x1));
    if (it.flip) begin
      nx = -nx;
      ny = -ny;
    end
    have_hit = 1;
    best.found = 1;
    best.prim = it.prim;
    best.geom = it.geom;
    best.scene = it.prim + it.off;
    best.nx = nx;
    best.ny = ny;
    best.param = s[16:0];
    best.dst = dist_v[31:0];
    radius = dist_v[31:0];
  endfunction

  // advance the query state for one accepted item, queue any result
  function automatic void predict_query(query_item_t it);
    hit_t r;
    case (it.req)
      REQ_BEGIN: begin
        pt_x = it.qx;
        pt_y = it.qy;
        radius = it.rad;
        query_ok = it.rad != 0;
        clear_best();
      end
      REQ_SEGMENT: if (query_ok) measure_segment(it);
      REQ_FINISH: begin
        r = best;
        r.status = !query_ok;
        r.found = have_hit;
        hit_expq.push_back(it.fixed ? it.want : r);
      end
      default: ;
    endcase
  endfunction

  function automatic query_item_t mk(bit [1:0] req, int qx, int qy, bit [31:0] rad,
                                     int x0, int y0, int x1, int y1,
                                     bit [31:0] prim, bit [31:0] geom,
                                     bit [31:0] off, bit fl);
    query_item_t it;
    it = '{default: 0};
    it.req = req; it.qx = qx; it.qy = qy; it.rad = rad;
    it.x0 = x0; it.y0 = y0; it.x1 = x1; it.y1 = y1;
    it.prim = prim; it.geom = geom; it.off = off; it.flip = fl;
    return it;
  endfunction

  function automatic query_item_t mk_invalid_finish();
    query_item_t it;
    it = mk(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    it.fixed = 1;
    it.want = '{default: 0};
    it.want.status = 1;
    return it;
  endfunction

  function automatic int near_coord(int c, int spread);
    return c + $signed($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic int any_coord();
    return $urandom();
  endfunction

  // directed table, then random query sequences
  task automatic build_stimulus();
    query_item_t it;
    int items, nseg, cx, cy, spread;
    bit wide;
    // nothing begun yet, segment ignored
    stim_q.push_back(mk_invalid_finish());
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, 0, 0, 65536, 0, 7, 8, 9, 0));
    stim_q.push_back(mk_invalid_finish());
    // zero radius makes the query invalid
    stim_q.push_back(mk(REQ_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, 0, 0, 65536, 0, 7, 8, 9, 0));
    stim_q.push_back(mk_invalid_finish());
    stim_q.push_back(mk(REQ_SPARE, -1, -1, '1, -1, -1, -1, -1, '1, '1, '1, 1));
    // valid query, degenerate, before start, past end, interior
    stim_q.push_back(mk(REQ_BEGIN, 0, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, 65536, 131072, 65536, 131072, 1, 2, 3, 0));
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, 65536, 65536, 196608, 65536, 4, 5, 6, 1));
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, -196608, 16384, -65536, 16384, 7, 8, 9, 0));
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, -65536, -4096, 131072, -4096,
                        '1, '1, 1, 1));
    stim_q.push_back(mk(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(mk(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // extreme coordinates, far segment too distant to ever record
    stim_q.push_back(mk(REQ_BEGIN, MAX_C, MAX_C, '1, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, MIN_C, MIN_C, MIN_C, MIN_C, 1, 1, 1, 0));
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, MIN_C, MAX_C, MAX_C, MIN_C,
                        32'h8000_0000, 32'h5555_aaaa, 32'h8000_0000, 1));
    stim_q.push_back(mk(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // segment through the point, distance zero below radius one
    stim_q.push_back(mk(REQ_BEGIN, MIN_C, MIN_C, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(mk(REQ_SEGMENT, 0, 0, 0, MIN_C, MIN_C, MIN_C + 10, MIN_C,
                        3, 4, 5, 0));
    stim_q.push_back(mk(REQ_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    items = 0;
    while (items < 900) begin
      // mostly well-formed queries with a few noise items
      wide = $urandom_range(9) == 0;
      cx = wide ? any_coord() : near_coord(0, 1 << 24);
      cy = wide ? any_coord() : near_coord(0, 1 << 24);
      spread = 1 << $urandom_range(20, 4);
      it = mk(REQ_BEGIN, cx, cy, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      case ($urandom_range(9))
        0: it.rad = 0;
        1, 2: it.rad = $urandom();
        3: it.rad = $urandom_range(spread);
        default: it.rad = '1;
      endcase
      if ($urandom_range(15) != 0) begin
        stim_q.push_back(it);
        items++;
      end
      nseg = $urandom_range(8);
      for (int i = 0; i < nseg; i++) begin
        it = mk(REQ_SEGMENT, any_coord(), any_coord(), $urandom(),
                0, 0, 0, 0, $urandom(), $urandom(), $urandom(), $urandom_range(1));
        if (wide || $urandom_range(15) == 0) begin
          it.x0 = any_coord(); it.y0 = any_coord();
          it.x1 = any_coord(); it.y1 = any_coord();
        end else begin
          it.x0 = near_coord(cx, spread); it.y0 = near_coord(cy, spread);
          it.x1 = near_coord(cx, spread); it.y1 = near_coord(cy, spread);
          if ($urandom_range(9) == 0) begin
            it.x1 = it.x0; it.y1 = it.y0;
          end
        end
        stim_q.push_back(it);
        items++;
        if ($urandom_range(29) == 0) begin
          it.req = REQ_SPARE;
          stim_q.push_back(it);
        end
      end
      stim_q.push_back(mk(REQ_FINISH, $urandom(), $urandom(), $urandom(),
                          0, 0, 0, 0, $urandom(), 0, 0, 0));
      items++;
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // reset and initial drive
  initial begin
    rst = 1; push = 0; pop = 0; req_type = '0; flip = 0;
    query_x = 0; query_y = 0; query_radius = 0;
    seg_x0 = 0; seg_y0 = 0; seg_x1 = 0; seg_y1 = 0;
    prim_id = 0; geom_id = 0; prim_offset = 0;
    pt_x = 0; pt_y = 0; radius = 0; query_ok = 0;
    clear_best();
    build_stimulus();
    repeat (7) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // item sender
  query_item_t cur_item;
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) predict_query(cur_item);
      if (!(push && full)) begin
        if (stim_q.size() > 0 && !idle_now()) begin
          cur_item = stim_q.pop_front();
          push <= 1;
          req_type <= cur_item.req;
          query_x <= cur_item.qx; query_y <= cur_item.qy;
          query_radius <= cur_item.rad;
          seg_x0 <= cur_item.x0; seg_y0 <= cur_item.y0;
          seg_x1 <= cur_item.x1; seg_y1 <= cur_item.y1;
          prim_id <= cur_item.prim; geom_id <= cur_item.geom;
          prim_offset <= cur_item.off; flip <= cur_item.flip;
        end else begin
          push <= 0;
          if (stim_q.size() == 0) stim_done <= 1;
        end
      end
    end
  end

  // result receiver and compare
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (hit_expq.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item");
        end else begin
          hit_t w;
          w = hit_expq.pop_front();
          check_field("status", w.status, status);
          check_field("found", w.found, found);
          check_field("hit_prim", w.prim, hit_prim);
          check_field("hit_geom", w.geom, hit_geom);
          check_field("hit_scene_prim", w.scene, hit_scene_prim);
          check_field("normal_x", w.nx, $unsigned(normal_x));
          check_field("normal_y", w.ny, $unsigned(normal_y));
          check_field("param_s", w.param, param_s);
          check_field("distance", w.dst, distance);
        end
      end
      pop <= calm() || $urandom_range(99) >= 11;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (hit_expq.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && hit_expq.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/seg_cpq_pkg.sv
hdl/seg_cpq_front.sv
hdl/seg_cpq_back.sv
hdl/segment_closest_point_query_core.sv
dv/tb_segment_closest_point_query_core.sv
